// ===== design/drf_pkg.sv =====
// Package for the device record ring: record layout, kind and status codes,
// and the per-cell shift control. No dependencies.
`default_nettype none

package drf_pkg;

  localparam int unsigned IdW   = 64;
  localparam int unsigned AddrW = 48;
  localparam int unsigned TypeW = 8;
  localparam int unsigned OccW  = 4;
  localparam int unsigned DataW = 192;

  typedef enum logic [1:0] {
    KIND_ENQ     = 2'd0,
    KIND_DEQ     = 2'd1,
    KIND_FIND_ID = 2'd2,
    KIND_FIND_AD = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_DUP   = 2'd1,
    STATUS_EVICT = 2'd2,
    STATUS_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHIFT = 2'd1,
    CELL_LOAD  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [IdW-1:0]   id_high;
    logic [IdW-1:0]   id_low;
    logic [AddrW-1:0] addr;
    logic [TypeW-1:0] btype;
  } record_t;

endpackage

`default_nettype wire

// ===== design/dedup_device_ring_fifo.sv =====
// Top level of the device record ring with duplicate check and key lookup.
// Depends on drf_pkg and drf_cell.
//
// Usage: one command item enters on the s_axis channel, its kind in tuser
// (enqueue, dequeue, lookup by identifier, lookup by address). One result
// item leaves on the m_axis channel for every command, status in tuser.
// The records sit in a row of RING_DEPTH cells, oldest in cell 0. For each
// command the whole row rotates once, one cell per cycle, so that every
// record passes cell 0 where a single identifier or address comparator
// looks at it; the first live match is captured. Once the rotation ends
// the row is back in place and the commit state applies the update
// (load at the fill position, or shift toward cell 0 to drop the oldest).
// An item passes through the rotation past the comparator at cell 0 and then
// the commit before its result is valid, and the next item is accepted only
// once that commit has taken place and the block is idle again.
// The finished result waits in an output register, and a new command is
// accepted while it waits. If the receiver stalls, the commit cycle of the
// following command holds until the output register is free.
// Reset empties the ring (record count zero); record contents are not
// cleared, since only live records are ever compared or returned.
`default_nettype none

module dedup_device_ring_fifo #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: uuid_high [63:0], uuid_low [127:64], device_addr [175:128],
  // bearer_type [183:176], exists_only [184], zero fill [191:185]
  input  wire logic [191:0] s_axis_tdata,
  // tuser: kind [1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: found_uuid_high [63:0], found_uuid_low [127:64],
  // found_addr [175:128], found_type [183:176], occupancy [187:184],
  // zero fill [191:188]
  output logic [191:0]      m_axis_tdata,
  // tuser: status [1:0]
  output logic [1:0]        m_axis_tuser
);

  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] step_q, step_d;
  logic            hit_q, hit_d;
  drf_pkg::record_t hit_rec_q, hit_rec_d;

  // Command held for the length of the operation.
  drf_pkg::kind_e   kind_q;
  drf_pkg::record_t cmd_q;
  logic             exists_q;

  logic              m_valid_q;
  logic [191:0]      m_data_q, m_data_d;
  drf_pkg::status_e  m_status_q, m_status_d;

  drf_pkg::record_t  rec  [RING_DEPTH];
  drf_pkg::cell_op_e cell_op [RING_DEPTH];

  logic accept, commit, full, match;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == ST_COMMIT) && (!m_valid_q || m_axis_tready);
  assign full          = (count_q == CntW'(RING_DEPTH));

  // Single comparator at the head cell. Enqueue checks the identifier.
  assign match = (kind_q == drf_pkg::KIND_FIND_AD) ? (rec[0].addr == cmd_q.addr)
               : ((rec[0].id_high == cmd_q.id_high) && (rec[0].id_low == cmd_q.id_low));

  // The chain: each cell takes the next one's record on a shift, and the last
  // cell takes cell 0's record, so that a full rotation restores the order.
  for (genvar g = 0; g < RING_DEPTH; g++) begin : g_cell
    localparam int unsigned Nxt = (g + 1) % RING_DEPTH;
    drf_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op[g]),
      .nbr_i  (rec[Nxt]),
      .load_i (cmd_q),
      .rec_o  (rec[g])
    );
  end

  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      cell_op[i] = drf_pkg::CELL_HOLD;
      if (state_q == ST_SCAN) begin
        cell_op[i] = drf_pkg::CELL_SHIFT;
      end else if (commit) begin
        case (kind_q)
          drf_pkg::KIND_ENQ: begin
            if (!hit_q) begin
              if (full) begin
                // Drop the oldest: shift down, newest lands in the last cell.
                cell_op[i] = (i == RING_DEPTH - 1) ? drf_pkg::CELL_LOAD
                                                   : drf_pkg::CELL_SHIFT;
              end else if (count_q == CntW'(i)) begin
                cell_op[i] = drf_pkg::CELL_LOAD;
              end
            end
          end
          drf_pkg::KIND_DEQ: begin
            if (count_q != '0) begin
              cell_op[i] = drf_pkg::CELL_SHIFT;
            end
          end
          default: cell_op[i] = drf_pkg::CELL_HOLD;
        endcase
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    hit_d      = hit_q;
    hit_rec_d  = hit_rec_q;
    count_d    = count_q;
    m_status_d = drf_pkg::STATUS_OK;
    m_data_d   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          step_d  = '0;
          hit_d   = 1'b0;
        end
      end
      ST_SCAN: begin
        if (!hit_q && (step_q < count_q) && match) begin
          hit_d     = 1'b1;
          hit_rec_d = rec[0];
        end
        step_d = step_q + CntW'(1);
        if (step_q == CntW'(RING_DEPTH - 1)) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Result of the commit cycle; only registered when commit is high.
    case (kind_q)
      drf_pkg::KIND_ENQ: begin
        if (hit_q) begin
          m_status_d = drf_pkg::STATUS_DUP;
        end else if (full) begin
          m_status_d = drf_pkg::STATUS_EVICT;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      drf_pkg::KIND_DEQ: begin
        if (count_q == '0) begin
          m_status_d = drf_pkg::STATUS_MISS;
        end else begin
          count_d         = count_q - CntW'(1);
          m_data_d[63:0]    = rec[0].id_high;
          m_data_d[127:64]  = rec[0].id_low;
          m_data_d[175:128] = rec[0].addr;
        end
      end
      default: begin
        if (!hit_q) begin
          m_status_d = drf_pkg::STATUS_MISS;
        end else if (!exists_q) begin
          if (kind_q == drf_pkg::KIND_FIND_AD) begin
            m_data_d[63:0]   = hit_rec_q.id_high;
            m_data_d[127:64] = hit_rec_q.id_low;
          end else begin
            m_data_d[175:128] = hit_rec_q.addr;
          end
          m_data_d[183:176] = hit_rec_q.btype;
        end
      end
    endcase
    m_data_d[187:184] = drf_pkg::OccW'(count_d);
    if (!commit) begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      step_q    <= '0;
      hit_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      hit_q   <= hit_d;
      if (commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_rec_q <= hit_rec_d;
    if (accept) begin
      kind_q        <= drf_pkg::kind_e'(s_axis_tuser);
      cmd_q.id_high <= s_axis_tdata[63:0];
      cmd_q.id_low  <= s_axis_tdata[127:64];
      cmd_q.addr    <= s_axis_tdata[175:128];
      cmd_q.btype   <= s_axis_tdata[183:176];
      exists_q      <= s_axis_tdata[184];
    end
    if (commit) begin
      m_data_q   <= m_data_d;
      m_status_q <= m_status_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(RING_DEPTH))
    else $error("record count above ring depth");

  a_scan_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(count_q))
    else $error("record count changed during a scan");

  a_dup_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (kind_q == drf_pkg::KIND_ENQ) && !hit_q) |=>
      (m_axis_tuser != drf_pkg::STATUS_DUP))
    else $error("duplicate reported without a match");
`endif

endmodule

`default_nettype wire

// ===== design/drf_cell.sv =====
// One cell of the record chain: holds one device record, and either keeps it,
// takes its neighbor's record or loads a new one. Depends on drf_pkg.
`default_nettype none

module drf_cell (
  input  wire logic              clk_i,
  input  wire drf_pkg::cell_op_e op_i,
  input  wire drf_pkg::record_t  nbr_i,
  input  wire drf_pkg::record_t  load_i,
  output drf_pkg::record_t       rec_o
);

  drf_pkg::record_t rec_q;

  always_ff @(posedge clk_i) begin
    case (op_i)
      drf_pkg::CELL_SHIFT: rec_q <= nbr_i;
      drf_pkg::CELL_LOAD:  rec_q <= load_i;
      default:             rec_q <= rec_q;
    endcase
  end

  assign rec_o = rec_q;

endmodule

`default_nettype wire
